FILE: rtl/prs_pkg.sv
// Types, codes and constant tables shared by the poll request scheduler.
`default_nettype none
package prs_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG = 6;
  localparam int POS_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RC       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTITUDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GPS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS   = 3'd5;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    16'd40, 16'd40, 16'd50, 16'd200, 16'd200, 16'd500
  };

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_FRAME = 2'd1;
  localparam logic [1:0] ACT_ERROR = 2'd2;

  localparam logic [7:0] STARTUP_CMD [4] = '{8'd1, 8'd2, 8'd3, 8'd0};
  localparam logic [7:0] PERIODIC_CMD [8] = '{
    8'd105, 8'd108, 8'd110, 8'd106, 8'd101, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [7:0]  frame_command;
    logic        link_ready;
  } in_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_command;
    logic        waiting_reply;
    logic [31:0] request_count;
    logic [31:0] timeout_count;
    logic [31:0] checksum_error_count;
    logic [31:0] last_frame_ms;
  } out_t;

  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] cmp;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        lt;
    logic        gt;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ARM,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/poll_request_scheduler_core.sv
// Top level of the poll request scheduler: sequencer, state and result register.
// A tick that reaches the periodic scan passes through the timeout check, one
// lateness step per periodic query, the re-arm and the result load, and in_ready
// returns on the edge that loads the result. A tick that stops at the check (still
// waiting or in start-up) goes from the check straight to the result load. Frame
// and checksum items go straight to the result load. The timeout check, the scan
// and the re-arm go through one shared 32-bit subtract/compare unit. in_ready is
// high only between items, and a finished result waits in the output register
// while the next item is taken; a result that is still held when the next one is
// ready stalls the sequencer until out_ready. Configuration writes are taken in
// any cycle.
`default_nettype none
module poll_request_scheduler_core
  import prs_pkg::*;
#(
  parameter int NUM_PERIODIC = 5,
  parameter int NUM_STARTUP  = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (NUM_PERIODIC > 1) ? $clog2(NUM_PERIODIC) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PERIODIC - 1);
  localparam logic [POS_W-1:0] START_END = POS_W'(NUM_STARTUP);

  state_t state, state_next;

  logic [CFG_W-1:0] cfg [NUM_CFG];
  logic [31:0]      due [NUM_PERIODIC];
  logic [POS_W-1:0] startup_pos;
  logic             pending;
  logic [7:0]       pending_cmd;
  logic [31:0]      sent_time;
  logic [31:0]      requests_sent;
  logic [31:0]      timeouts_seen;
  logic [31:0]      checksum_errors_seen;
  logic [31:0]      last_valid_time;

  in_t              item;
  logic             sent;
  logic [7:0]       scmd;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] sel;
  logic             found;
  logic [31:0]      best;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic             in_accept;
  logic             load_out;
  logic             startup_active;
  logic             still_waiting;
  logic [3:0]       sel_ext;
  logic [CFG_IDX_W-1:0] period_idx;

  prs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign cfg_ready      = 1'b1;
  assign in_accept      = in_valid && in_ready;
  assign startup_active = startup_pos < START_END;
  assign still_waiting  = pending && alu_rsp.lt;
  assign sel_ext        = 4'(sel);
  assign period_idx     = (sel_ext < 4'd5) ? CFG_IDX_W'(sel_ext + 4'd1) : CFG_STATUS;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (in_data.action == ACT_TICK) ? S_CHECK : S_DONE;
        end
      end
      S_CHECK: begin
        if (still_waiting || startup_active) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = S_ARM;
        end
      end
      S_ARM:   state_next = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    load_out    = 1'b0;
    alu_req.sub = 1'b1;
    alu_req.a   = item.now_ms;
    alu_req.b   = sent_time;
    alu_req.cmp = {16'd0, cfg[CFG_TIMEOUT]};
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_CHECK: ;
      S_SCAN: begin
        alu_req.b   = due[idx];
        alu_req.cmp = best;
      end
      S_ARM: begin
        alu_req.sub = 1'b0;
        alu_req.b   = {16'd0, cfg[period_idx]};
        alu_req.cmp = 32'd0;
      end
      S_DONE:  load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      out_valid            <= 1'b0;
      startup_pos          <= '0;
      pending              <= 1'b0;
      pending_cmd          <= '0;
      sent_time            <= '0;
      requests_sent        <= '0;
      timeouts_seen        <= '0;
      checksum_errors_seen <= '0;
      last_valid_time      <= '0;
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg[i] <= CFG_RESET[i];
      end
      for (int i = 0; i < NUM_PERIODIC; i++) begin
        due[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_CFG)) begin
        cfg[cfg_index] <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            item <= in_data;
            sent <= 1'b0;
            scmd <= '0;
            unique case (in_data.action)
              ACT_FRAME: begin
                last_valid_time <= in_data.now_ms;
                if (pending && (in_data.frame_command == pending_cmd)) begin
                  pending <= 1'b0;
                end
              end
              ACT_ERROR: checksum_errors_seen <= checksum_errors_seen + 32'd1;
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          idx   <= '0;
          found <= 1'b0;
          best  <= '0;
          if (!still_waiting) begin
            if (pending) begin
              pending       <= 1'b0;
              timeouts_seen <= timeouts_seen + 32'd1;
            end
            if (startup_active && item.link_ready) begin
              pending       <= 1'b1;
              pending_cmd   <= STARTUP_CMD[startup_pos];
              sent_time     <= item.now_ms;
              requests_sent <= requests_sent + 32'd1;
              sent          <= 1'b1;
              scmd          <= STARTUP_CMD[startup_pos];
              startup_pos   <= startup_pos + POS_W'(1);
              if (startup_pos + POS_W'(1) == START_END) begin
                for (int i = 0; i < NUM_PERIODIC; i++) begin
                  due[i] <= item.now_ms;
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (!alu_rsp.sum[31] && (!found || alu_rsp.gt)) begin
            sel   <= idx;
            best  <= alu_rsp.sum;
            found <= 1'b1;
          end
          idx <= idx + IDX_W'(1);
        end
        S_ARM: begin
          if (found && item.link_ready) begin
            due[sel]      <= alu_rsp.sum;
            pending       <= 1'b1;
            pending_cmd   <= PERIODIC_CMD[3'(sel)];
            sent_time     <= item.now_ms;
            requests_sent <= requests_sent + 32'd1;
            sent          <= 1'b1;
            scmd          <= PERIODIC_CMD[3'(sel)];
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_data.send_valid           <= sent;
            out_data.send_command         <= scmd;
            out_data.waiting_reply        <= pending;
            out_data.request_count        <= requests_sent;
            out_data.timeout_count        <= timeouts_seen;
            out_data.checksum_error_count <= checksum_errors_seen;
            out_data.last_frame_ms        <= last_valid_time;
          end
        end
        default: ;
      endcase
    end
  end

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (state == S_SCAN || state == S_ARM))
    else $error("scan left to an unexpected state");

  a_startup_bound: assert property (@(posedge clk) disable iff (rst)
    startup_pos <= START_END)
    else $error("start-up position past its end");

  a_send_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && sent) |-> pending)
    else $error("request sent without a pending wait");

  a_tick_check: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.action == ACT_TICK) |=> (state == S_CHECK))
    else $error("tick transfer did not start the timeout check");

endmodule
`default_nettype wire

FILE: rtl/prs_alu.sv
// Shared add/subtract and compare unit used by the check, scan and re-arm steps of the sequencer.
`default_nettype none
module prs_alu
  import prs_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [31:0] operand;
  logic [31:0] sum;

  assign operand = req.sub ? ~req.b : req.b;
  assign sum     = req.a + operand + {31'd0, req.sub};

  assign rsp.sum = sum;
  assign rsp.lt  = sum < req.cmp;
  assign rsp.gt  = sum > req.cmp;

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the poll request scheduler core.
`default_nettype none
module tb
  import prs_pkg::*;
();

  localparam int NUM_PERIODIC = 5;
  localparam int NUM_STARTUP  = 3;
  localparam int TICK_CYCLES  = NUM_PERIODIC + 4;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [7:0] BOOT_QUERY [NUM_STARTUP] = '{8'd1, 8'd2, 8'd3};
  localparam logic [7:0] POLL_QUERY [NUM_PERIODIC] = '{
    8'd105, 8'd108, 8'd110, 8'd106, 8'd101
  };
  localparam logic [CFG_W-1:0] DEFAULT_CFG [NUM_CFG] = '{
    16'd40, 16'd40, 16'd50, 16'd200, 16'd200, 16'd500
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  poll_request_scheduler_core #(
    .NUM_PERIODIC(NUM_PERIODIC),
    .NUM_STARTUP (NUM_STARTUP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler shadow state
  logic [CFG_W-1:0] cfg_shadow [NUM_CFG] = DEFAULT_CFG;
  logic [1:0]       boot_step = '0;
  logic [31:0]      due_at [NUM_PERIODIC] = '{default: '0};
  logic             awaiting = 1'b0;
  logic [7:0]       await_cmd = '0;
  logic [31:0]      issued_at = '0;
  logic [31:0]      sent_total = '0;
  logic [31:0]      timeout_total = '0;
  logic [31:0]      crc_total = '0;
  logic [31:0]      last_rx = '0;

  out_t        predicted_reports [$];
  out_t        want_rep;
  int          mismatch_count = 0;
  bit          gap_on = 1'b1;
  bit          stall_on = 1'b1;
  int          ready_hold = 0;
  logic [31:0] now_clk = '0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t make_item(input logic [1:0] act, input logic [31:0] t,
                                    input logic [7:0] cmd, input logic rdy);
    in_t it;
    it.action        = act;
    it.now_ms        = t;
    it.frame_command = cmd;
    it.link_ready    = rdy;
    return it;
  endfunction

  function automatic logic [NUM_CFG-1:0][CFG_W-1:0] pack_settings(
      input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] rc,
      input logic [CFG_W-1:0] att, input logic [CFG_W-1:0] ana,
      input logic [CFG_W-1:0] gps, input logic [CFG_W-1:0] sts);
    logic [NUM_CFG-1:0][CFG_W-1:0] r;
    r[CFG_TIMEOUT]  = tmo;
    r[CFG_RC]       = rc;
    r[CFG_ATTITUDE] = att;
    r[CFG_ANALOG]   = ana;
    r[CFG_GPS]      = gps;
    r[CFG_STATUS]   = sts;
    return r;
  endfunction

  function automatic void launch(input logic [7:0] cmd, input logic [31:0] t);
    awaiting   = 1'b1;
    await_cmd  = cmd;
    issued_at  = t;
    sent_total = sent_total + 32'd1;
  endfunction

  function automatic out_t advance_scheduler(input in_t it);
    out_t        rep;
    logic        go;
    logic [31:0] late;
    logic [31:0] best;
    int          sel;
    rep = '0;
    case (it.action)
      ACT_TICK: begin
        go = 1'b1;
        if (awaiting) begin
          late = it.now_ms - issued_at;
          if (late < 32'(cfg_shadow[CFG_TIMEOUT])) begin
            go = 1'b0;
          end else begin
            awaiting      = 1'b0;
            timeout_total = timeout_total + 32'd1;
          end
        end
        if (go && boot_step < NUM_STARTUP) begin
          if (it.link_ready) begin
            rep.send_valid   = 1'b1;
            rep.send_command = BOOT_QUERY[boot_step];
            launch(BOOT_QUERY[boot_step], it.now_ms);
            boot_step = boot_step + 2'd1;
            if (boot_step == NUM_STARTUP) begin
              for (int i = 0; i < NUM_PERIODIC; i++) due_at[i] = it.now_ms;
            end
          end
        end else if (go) begin
          sel  = -1;
          best = '0;
          for (int i = 0; i < NUM_PERIODIC; i++) begin
            late = it.now_ms - due_at[i];
            if (!late[31] && (sel < 0 || late > best)) begin
              sel  = i;
              best = late;
            end
          end
          if (sel >= 0 && it.link_ready) begin
            rep.send_valid   = 1'b1;
            rep.send_command = POLL_QUERY[sel];
            launch(POLL_QUERY[sel], it.now_ms);
            due_at[sel] = it.now_ms + 32'(cfg_shadow[1 + sel]);
          end
        end
      end
      ACT_FRAME: begin
        last_rx = it.now_ms;
        if (awaiting && it.frame_command == await_cmd) awaiting = 1'b0;
      end
      ACT_ERROR: begin
        crc_total = crc_total + 32'd1;
      end
      default: begin
      end
    endcase
    rep.waiting_reply        = awaiting;
    rep.request_count        = sent_total;
    rep.timeout_count        = timeout_total;
    rep.checksum_error_count = crc_total;
    rep.last_frame_ms        = last_rx;
    return rep;
  endfunction

  task automatic send_item(input in_t item);
    int gap;
    gap = gap_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_reports.push_back(advance_scheduler(item));
  endtask

  // hold off until every predicted report has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [NUM_CFG-1:0][CFG_W-1:0] regs,
                               input bit touch_spare);
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= regs[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_shadow[i] = regs[i];
    end
    if (touch_spare) begin
      cfg_index <= CFG_SPARE_LO;
      cfg_data  <= CFG_W'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_index <= CFG_SPARE_HI;
      cfg_data  <= CFG_W'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_startup_sequence();
    send_item(make_item(ACT_UNUSED, 32'd5, 8'hFF, 1'b1));
    send_item(make_item(ACT_FRAME, 32'hFFFF_FFFF, 8'h00, 1'b0));
    send_item(make_item(ACT_ERROR, 32'd0, 8'hAA, 1'b1));
    send_item(make_item(ACT_TICK, 32'd10, 8'h55, 1'b0));
    send_item(make_item(ACT_TICK, 32'd10, 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'd20, 8'h00, 1'b1));
    send_item(make_item(ACT_FRAME, 32'd21, 8'd2, 1'b1));
    send_item(make_item(ACT_FRAME, 32'd22, 8'd1, 1'b0));
    send_item(make_item(ACT_TICK, 32'd25, 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'd65, 8'h00, 1'b1));
    send_item(make_item(ACT_FRAME, 32'd70, 8'd3, 1'b0));
    send_item(make_item(ACT_TICK, 32'd70, 8'h00, 1'b1));
    send_item(make_item(ACT_FRAME, 32'd71, 8'd105, 1'b0));
    send_item(make_item(ACT_TICK, 32'd72, 8'h00, 1'b0));
    send_item(make_item(ACT_TICK, 32'd72, 8'h00, 1'b1));
    settle();
  endtask

  task automatic test_zero_timeout_and_period();
    load_settings(pack_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
    send_item(make_item(ACT_TICK, 32'd100, 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'd100, 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'd101, 8'h00, 1'b0));
    send_item(make_item(ACT_TICK, 32'd101, 8'h00, 1'b1));
    settle();
  endtask

  task automatic test_nothing_due();
    load_settings(pack_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                  1'b0);
    for (int t = 200; t < 206; t++) send_item(make_item(ACT_TICK, 32'(t), 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'd70200, 8'h00, 1'b1));
    settle();
  endtask

  task automatic test_time_wrap();
    load_settings(pack_settings(16'hFFFF, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd7), 1'b0);
    send_item(make_item(ACT_TICK, 32'hFFFF_FFF0, 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'hFFFF_FFFE, 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'h0000_0003, 8'h00, 1'b1));
    send_item(make_item(ACT_TICK, 32'h7FFF_FFF0, 8'h00, 1'b1));
    settle();
  endtask

  task automatic test_random_traffic(input int count, input bit gaps, input bit stalls,
                                     input logic [NUM_CFG-1:0][CFG_W-1:0] regs,
                                     input bit touch_spare);
    in_t item;
    int  roll;
    gap_on   = gaps;
    stall_on = stalls;
    load_settings(regs, touch_spare);
    now_clk = $urandom;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        now_clk += $urandom_range(0, 25);
        item = make_item(ACT_TICK, now_clk, 8'($urandom), $urandom_range(0, 99) < 85);
      end else if (roll < 75) begin
        now_clk += $urandom_range(0, 5);
        item = make_item(ACT_FRAME, now_clk, awaiting ? await_cmd : 8'($urandom),
                         1'($urandom));
      end else if (roll < 83) begin
        item = make_item(ACT_FRAME, now_clk, 8'($urandom), 1'($urandom));
      end else if (roll < 90) begin
        item = make_item(ACT_ERROR, now_clk, 8'($urandom), 1'($urandom));
      end else if (roll < 93) begin
        item = make_item(ACT_UNUSED, $urandom, 8'($urandom), 1'($urandom));
      end else begin
        now_clk = $urandom;
        item = make_item(ACT_TICK, now_clk, 8'($urandom), 1'b1);
      end
      send_item(item);
    end
    settle();
  endtask

  always @(posedge clk) begin
    if (!stall_on) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_reports.size() == 0) begin
        $error("report with no prediction: %h", out_data);
        mismatch_count = mismatch_count + 1;
      end else begin
        want_rep = predicted_reports.pop_front();
        if (out_data.send_valid !== want_rep.send_valid) begin
          $error("send_valid expected %0d got %0d", want_rep.send_valid,
                 out_data.send_valid);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.send_command !== want_rep.send_command) begin
          $error("send_command expected %0d got %0d", want_rep.send_command,
                 out_data.send_command);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.waiting_reply !== want_rep.waiting_reply) begin
          $error("waiting_reply expected %0d got %0d", want_rep.waiting_reply,
                 out_data.waiting_reply);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.request_count !== want_rep.request_count) begin
          $error("request_count expected %0d got %0d", want_rep.request_count,
                 out_data.request_count);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.timeout_count !== want_rep.timeout_count) begin
          $error("timeout_count expected %0d got %0d", want_rep.timeout_count,
                 out_data.timeout_count);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.checksum_error_count !== want_rep.checksum_error_count) begin
          $error("checksum_error_count expected %0d got %0d",
                 want_rep.checksum_error_count, out_data.checksum_error_count);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.last_frame_ms !== want_rep.last_frame_ms) begin
          $error("last_frame_ms expected %0d got %0d", want_rep.last_frame_ms,
                 out_data.last_frame_ms);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_startup_sequence();
    test_zero_timeout_and_period();
    test_nothing_due();
    test_time_wrap();
    test_random_traffic(150, 1'b1, 1'b1,
                        pack_settings(16'($urandom_range(1, 60)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100))), 1'b0);
    test_random_traffic(150, 1'b0, 1'b0,
                        pack_settings(16'($urandom_range(1, 60)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100)),
                                      16'($urandom_range(1, 100))), 1'b0);
    test_random_traffic(150, 1'b1, 1'b1,
                        pack_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF),
                        1'b1);
    test_random_traffic(150, 1'b1, 1'b0,
                        pack_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1), 1'b0);
    test_random_traffic(150, 1'b0, 1'b1,
                        pack_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom)), 1'b1);
    test_random_traffic(150, 1'b1, 1'b1,
                        pack_settings(16'd0,
                                      16'($urandom_range(0, 30)),
                                      16'($urandom_range(0, 30)),
                                      16'($urandom_range(0, 30)),
                                      16'($urandom_range(0, 30)),
                                      16'($urandom_range(0, 30))), 1'b0);
    repeat (4 * TICK_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: poll_request_scheduler_core.f
rtl/prs_pkg.sv
rtl/prs_alu.sv
rtl/poll_request_scheduler_core.sv
bench/tb.sv
